/* hw/rtl/hsc_pkg.sv */
// ----------------------------------------------------------------------------
// hsc_pkg: shared constants, types and functions of the hamming sec codec
// sizes of the code, result record and the position map helpers
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

    localparam int DATA_BYTES = 4;
    localparam int KBITS      = 8 * DATA_BYTES;

    // fewest check bits r with k + r + 1 <= 2^r
    function automatic int calc_rbits(input int k);
        int r;
        r = 0;
        while (k + r + 1 > (1 << r)) begin
            r = r + 1;
        end
        return r;
    endfunction

    localparam int RBITS = calc_rbits(KBITS);
    localparam int NBITS = KBITS + RBITS;

    typedef logic [KBITS-1:0] data_t;
    typedef logic [NBITS-1:0] code_t;
    typedef logic [RBITS-1:0] syn_t;

    typedef struct packed {
        code_t code;
        data_t data;
        syn_t  syndrome;
        logic  corrected;
        logic  uncorrectable;
    } hsc_result_t;

    function automatic logic is_pow2(input int p);
        return ((p & (p - 1)) == 0);
    endfunction

    // data bits into the non-power-of-two positions, msb first; check slots zero
    function automatic code_t place_data(input data_t d);
        code_t w;
        int    di;
        w  = '0;
        di = 0;
        for (int p = 1; p <= NBITS; p++) begin
            if (!is_pow2(p)) begin
                w[NBITS-p] = d[KBITS-1-di];
                di = di + 1;
            end
        end
        return w;
    endfunction

    // pull the data bits back out of the non-power-of-two positions
    function automatic data_t extract_data(input code_t w);
        data_t d;
        int    di;
        d  = '0;
        di = 0;
        for (int p = 1; p <= NBITS; p++) begin
            if (!is_pow2(p)) begin
                d[KBITS-1-di] = w[NBITS-p];
                di = di + 1;
            end
        end
        return d;
    endfunction

    // xor of the positions of all set bits: one parity tree per syndrome bit
    function automatic syn_t calc_syndrome(input code_t w);
        syn_t s;
        s = '0;
        for (int p = 1; p <= NBITS; p++) begin
            if (w[NBITS-p]) begin
                s = s ^ syn_t'(p);
            end
        end
        return s;
    endfunction

    // check bits of the syndrome placed at positions 2^j
    function automatic code_t place_checks(input syn_t s);
        code_t w;
        w = '0;
        for (int j = 0; j < RBITS; j++) begin
            w[NBITS-(1<<j)] = s[j];
        end
        return w;
    endfunction

    // one-hot flip mask for the addressed position, empty when out of range
    function automatic code_t flip_mask(input syn_t s);
        code_t w;
        w = '0;
        for (int p = 1; p <= NBITS; p++) begin
            w[NBITS-p] = (s == syn_t'(p));
        end
        return w;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/hsc_fix.sv */
// ----------------------------------------------------------------------------
// hsc_fix: final step of the codec
// adds check bits (encode) or flips the addressed bit (correct), extracts data
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_fix (
    input  wire logic               mode,
    input  wire hsc_pkg::code_t     word,
    input  wire hsc_pkg::syn_t      syn,
    output hsc_pkg::hsc_result_t    result
);
    import hsc_pkg::*;

    code_t fixed_word;
    logic  in_range;
    logic  beyond;

    assign in_range = (syn != '0) && (syn <= syn_t'(NBITS));
    assign beyond   = (syn > syn_t'(NBITS));

    always_comb
    begin
        if (mode) begin
            fixed_word = word ^ flip_mask(syn);
        end
        else begin
            fixed_word = word | place_checks(syn);
        end
    end

    always_comb
    begin
        result.code          = fixed_word;
        result.data          = extract_data(fixed_word);
        result.syndrome      = mode ? syn : '0;
        result.corrected     = mode & in_range;
        result.uncorrectable = mode & beyond;
    end

endmodule

`default_nettype wire

/* hw/rtl/hamming_sec_codec_core.sv */
// ----------------------------------------------------------------------------
// hamming_sec_codec_core: hamming single-error-correcting encoder/corrector
// three-stage pipeline with valid/ready on input and output
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  input   | in        | in_valid / in_ready  | mode, data_word, code_word
//  output  | out       | out_valid / out_ready| code_out, data_out, syndrome,
//          |           |                      | corrected, uncorrectable
//
//  one item per clock sustained while the output is not stalled; an item
//  passes through three register stages in order (word build, syndrome
//  parity trees, fix-up and extract), the first loaded at the accepting
//  edge and the last being the output register.
//  reset clears the three stage valid bits only; there is no state to clear.
//  a stall at the output backs up stage by stage; a stage takes a new item
//  whenever it is empty or its item moves on in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hamming_sec_codec_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // input channel
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           mode,
    input  wire hsc_pkg::data_t data_word,
    input  wire hsc_pkg::code_t code_word,
    // output channel
    output logic                out_valid,
    input  wire logic           out_ready,
    output hsc_pkg::code_t      code_out,
    output hsc_pkg::data_t      data_out,
    output hsc_pkg::syn_t       syndrome,
    output logic                corrected,
    output logic                uncorrectable
);
    import hsc_pkg::*;

    // stage 1: working word (data placed into code positions, or received word)
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_mode_reg;
    code_t       s1_word_reg;
    // stage 2: word plus its syndrome
    logic        s2_valid_reg, s2_valid_next;
    logic        s2_mode_reg;
    code_t       s2_word_reg;
    syn_t        s2_syn_reg;
    // stage 3: output register
    logic        s3_valid_reg, s3_valid_next;
    hsc_result_t s3_result_reg;

    hsc_result_t fix_result;

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;

    // a stage can load when it is empty or its item leaves this cycle
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign s1_valid_next = s1_ready ? in_valid     : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // stage 1: encode places data bits with empty check slots, so the
    // syndrome of that word is exactly the set of check bits to add
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid) begin
            s1_mode_reg <= mode;
            s1_word_reg <= mode ? code_word : place_data(data_word);
        end
    end

    // stage 2: parity trees
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg) begin
            s2_mode_reg <= s1_mode_reg;
            s2_word_reg <= s1_word_reg;
            s2_syn_reg  <= calc_syndrome(s1_word_reg);
        end
    end

    // stage 3: check insertion or single-bit correction, data extraction
    hsc_fix u_fix (
        .mode   (s2_mode_reg),
        .word   (s2_word_reg),
        .syn    (s2_syn_reg),
        .result (fix_result)
    );

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg) begin
            s3_result_reg <= fix_result;
        end
    end

    assign out_valid     = s3_valid_reg;
    assign code_out      = s3_result_reg.code;
    assign data_out      = s3_result_reg.data;
    assign syndrome      = s3_result_reg.syndrome;
    assign corrected     = s3_result_reg.corrected;
    assign uncorrectable = s3_result_reg.uncorrectable;

endmodule

`default_nettype wire

/* hw/rtl/hsc_checker.sv */
// ----------------------------------------------------------------------------
// hsc_checker: port-level assertions for the hamming sec codec
// output handshake rules and consistency of the result flags
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           out_valid,
    input wire logic           out_ready,
    input wire hsc_pkg::code_t code_out,
    input wire hsc_pkg::syn_t  syndrome,
    input wire logic           corrected,
    input wire logic           uncorrectable
);
    import hsc_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    // a stalled result keeps its codeword
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(code_out))
        else $error("output codeword changed while stalled");

    // at most one of the flags
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(corrected && uncorrectable))
        else $error("corrected and uncorrectable both set");

    // corrected only for an in-range nonzero syndrome
    a_corr_syn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && corrected |-> (syndrome != '0) && (syndrome <= syn_t'(NBITS)))
        else $error("corrected with out-of-range syndrome");

    // uncorrectable only for a syndrome past the codeword
    a_unc_syn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && uncorrectable |-> (syndrome > syn_t'(NBITS)))
        else $error("uncorrectable with in-range syndrome");

endmodule

bind hamming_sec_codec_core hsc_checker u_hsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .code_out      (code_out),
    .syndrome      (syndrome),
    .corrected     (corrected),
    .uncorrectable (uncorrectable)
);

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the hamming sec codec core
// streams encode and correct items through the valid/ready pipeline while
// both sides stall at random, predicts every result item from the code
// definition and compares each output item field by field in arrival order
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import hsc_pkg::*;

    localparam logic MODE_ENCODE  = 1'b0;
    localparam logic MODE_CORRECT = 1'b1;

    localparam int IDLE_PCT     = 11;
    localparam int QUIET_FROM   = 250;      // no idling on either side in this window
    localparam int QUIET_TO     = 400;
    localparam int HOLD_START   = 100;      // receiver back-pressure burst
    localparam int HOLD_LEN     = 60;
    localparam int DRAIN_CYCLES = 12;       // three register stages, with slack
    localparam int CYCLE_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 400;
    localparam int PRINT_CAP    = 100;

    typedef struct {
        logic  mode;
        data_t data;
        code_t code;
    } codec_item_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        mode      = MODE_ENCODE;
    data_t       data_word = '0;
    code_t       code_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    code_t       code_out;
    data_t       data_out;
    syn_t        syndrome;
    logic        corrected;
    logic        uncorrectable;

    codec_item_t words_to_send[$];
    hsc_result_t codec_results_q[$];
    codec_item_t next_word;
    hsc_result_t oldest_result;
    int          mismatch_count = 0;
    int          cycle_cnt      = 0;
    int          hold_timer     = 0;
    int          hold_left      = 0;
    logic        hold_done      = 1'b0;

    hamming_sec_codec_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .data_word     (data_word),
        .code_word     (code_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .code_out      (code_out),
        .data_out      (data_out),
        .syndrome      (syndrome),
        .corrected     (corrected),
        .uncorrectable (uncorrectable)
    );

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // data msb first into non-power-of-two positions, parity at 2^j
    function automatic code_t hamming_encode(input data_t d);
        code_t w;
        syn_t  s;
        int    p;
        int    di;
        w  = '0;
        s  = '0;
        di = 0;
        for (p = 1; p <= NBITS; p++) begin
            if ((p & (p - 1)) != 0) begin
                w[NBITS-p] = d[KBITS-1-di];
                if (d[KBITS-1-di])
                    s = s ^ syn_t'(p);
                di++;
            end
        end
        for (p = 1; p <= NBITS; p = p << 1) begin
            if ((int'(s) & p) != 0)
                w[NBITS-p] = 1'b1;
        end
        return w;
    endfunction

    function automatic hsc_result_t hamming_codec_result(input logic m, input data_t d,
                                                         input code_t c);
        hsc_result_t r;
        code_t       w;
        syn_t        s;
        int          p;
        int          di;
        r = '0;
        if (m == MODE_ENCODE) begin
            r.code = hamming_encode(d);
            r.data = d;
        end
        else begin
            w = c;
            s = '0;
            for (p = 1; p <= NBITS; p++) begin
                if (w[NBITS-p])
                    s = s ^ syn_t'(p);
            end
            if (int'(s) >= 1 && int'(s) <= NBITS) begin
                w[NBITS-int'(s)] = ~w[NBITS-int'(s)];
                r.corrected = 1'b1;
            end
            else if (int'(s) > NBITS) begin
                r.uncorrectable = 1'b1;
            end
            di = 0;
            for (p = 1; p <= NBITS; p++) begin
                if ((p & (p - 1)) != 0) begin
                    r.data[KBITS-1-di] = w[NBITS-p];
                    di++;
                end
            end
            r.code     = w;
            r.syndrome = s;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic code_t flip_position(input code_t w, input int p);
        code_t f;
        f          = w;
        f[NBITS-p] = ~f[NBITS-p];
        return f;
    endfunction

    function automatic code_t random_code();
        return code_t'({$urandom, $urandom});
    endfunction

    task automatic add_word(input logic m, input data_t d, input code_t c);
        codec_item_t it;
        it.mode = m;
        it.data = d;
        it.code = c;
        words_to_send.push_back(it);
    endtask

    // random idling, switched off inside the quiet window
    function automatic logic idle_now(input int cyc);
        if (cyc >= QUIET_FROM && cyc < QUIET_TO)
            return 1'b0;
        return ($urandom_range(99) < IDLE_PCT);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // clock, reset, cycle limit
    // ------------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // input driver: next item goes out once the current one is taken
    // ------------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            mode      <= MODE_ENCODE;
            data_word <= '0;
            code_word <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (words_to_send.size() != 0 && !idle_now(cycle_cnt))
            begin
                next_word = words_to_send.pop_front();
                mode      <= next_word.mode;
                data_word <= next_word.data;
                code_word <= next_word.code;
                in_valid  <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // output ready: random stalls plus one long hold-off to fill the pipe
    // ------------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            hold_timer <= 0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
        end
        else
        begin
            hold_timer <= hold_timer + 1;
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (!hold_done && hold_timer == HOLD_START)
            begin
                hold_left <= HOLD_LEN;
                hold_done <= 1'b1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= !idle_now(hold_timer);
            end
        end
    end

    // ------------------------------------------------------------------------
    // scoreboard: outputs checked before this edge's input is queued
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (codec_results_q.size() == 0)
                begin
                    report_mismatch("output item with nothing outstanding");
                end
                else
                begin
                    oldest_result = codec_results_q.pop_front();
                    if (code_out !== oldest_result.code)
                        report_mismatch($sformatf("code_out %h, want %h",
                                                  code_out, oldest_result.code));
                    if (data_out !== oldest_result.data)
                        report_mismatch($sformatf("data_out %h, want %h",
                                                  data_out, oldest_result.data));
                    if (syndrome !== oldest_result.syndrome)
                        report_mismatch($sformatf("syndrome %0d, want %0d",
                                                  syndrome, oldest_result.syndrome));
                    if (corrected !== oldest_result.corrected)
                        report_mismatch($sformatf("corrected %b, want %b",
                                                  corrected, oldest_result.corrected));
                    if (uncorrectable !== oldest_result.uncorrectable)
                        report_mismatch($sformatf("uncorrectable %b, want %b",
                                                  uncorrectable,
                                                  oldest_result.uncorrectable));
                end
            end
            if (in_valid && in_ready)
                codec_results_q.push_back(hamming_codec_result(mode, data_word, code_word));
        end
    end

    // ------------------------------------------------------------------------
    // item list and end of run
    // ------------------------------------------------------------------------

    initial
    begin : main_seq
        code_t clean;
        int    sel;
        int    p1;
        int    p2;

        // encode extremes, unused code_word random junk, all ones or all zeros
        add_word(MODE_ENCODE, 32'h0000_0000, random_code());
        add_word(MODE_ENCODE, 32'hFFFF_FFFF, random_code());
        add_word(MODE_ENCODE, 32'h8000_0000, '1);
        add_word(MODE_ENCODE, 32'h0000_0001, '0);
        add_word(MODE_ENCODE, 32'hAAAA_AAAA, random_code());
        add_word(MODE_ENCODE, 32'h5555_5555, random_code());

        // correct mode: zero word, all ones, clean word, junk data_word
        clean = hamming_encode(32'hDEAD_BEEF);
        add_word(MODE_CORRECT, '1, '0);
        add_word(MODE_CORRECT, '0, '1);
        add_word(MODE_CORRECT, $urandom, clean);
        add_word(MODE_CORRECT, $urandom, hamming_encode(32'hFFFF_FFFF));
        // single flips: check bits, first data bit, last and highest check position
        add_word(MODE_CORRECT, $urandom, flip_position(clean, 1));
        add_word(MODE_CORRECT, $urandom, flip_position(clean, 2));
        add_word(MODE_CORRECT, $urandom, flip_position(clean, 3));
        add_word(MODE_CORRECT, $urandom, flip_position(clean, 32));
        add_word(MODE_CORRECT, $urandom, flip_position(clean, NBITS));
        add_word(MODE_CORRECT, $urandom, flip_position(hamming_encode('0), NBITS));
        // double error lands on a wrong position
        add_word(MODE_CORRECT, $urandom, flip_position(flip_position(clean, 5), 9));
        // syndrome equal to the word length still flips
        add_word(MODE_CORRECT, $urandom, flip_position(flip_position(clean, 32), 6));
        // syndrome just past the word length and at its maximum
        add_word(MODE_CORRECT, $urandom, flip_position(flip_position(clean, 32), 7));
        add_word(MODE_CORRECT, $urandom, flip_position(flip_position(clean, 32), 31));

        // random part: mostly clean or single-error words with random content
        repeat (RANDOM_ITEMS)
        begin
            sel = $urandom_range(99);
            clean = hamming_encode($urandom);
            if (sel < 30)
            begin
                add_word(MODE_ENCODE, $urandom, random_code());
            end
            else if (sel < 55)
            begin
                add_word(MODE_CORRECT, $urandom, clean);
            end
            else if (sel < 85)
            begin
                add_word(MODE_CORRECT, $urandom, flip_position(clean, $urandom_range(NBITS, 1)));
            end
            else if (sel < 93)
            begin
                p1 = $urandom_range(NBITS, 1);
                p2 = $urandom_range(NBITS - 1, 1);
                if (p2 >= p1)
                    p2++;
                add_word(MODE_CORRECT, $urandom,
                         flip_position(flip_position(clean, p1), p2));
            end
            else
            begin
                add_word(MODE_CORRECT, $urandom, random_code());
            end
        end

        // wait on the falling edge so the driver and scoreboard have settled
        @(negedge clk);
        while (!rst_n || words_to_send.size() != 0 || in_valid)
            @(negedge clk);
        while (codec_results_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
